// ===== rtl/core/mmd_pkg.sv =====
// Package for the min/max decimator: widths, request types and register indexes.
`default_nettype none

package mmd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TIME_WIDTH   = 48;
    localparam int LEN_WIDTH    = 13;
    localparam int GAIN_WIDTH   = 16;
    localparam int COUNT_WIDTH  = 12;
    localparam int POINT_WIDTH  = 24;
    localparam int CFG_WIDTH    = 16;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + GAIN_WIDTH + 1;
    localparam int SHIFT_WIDTH  = PROD_WIDTH - 8;

    localparam logic [LEN_WIDTH-1:0]  MaxWindow   = LEN_WIDTH'(4096);
    localparam logic [LEN_WIDTH-1:0]  ResetWindow = LEN_WIDTH'(4);
    localparam logic [GAIN_WIDTH-1:0] ResetGain   = GAIN_WIDTH'(256);

    typedef enum logic
    {
        REG_WINDOW_LENGTH = 1'b0,
        REG_GAIN          = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic [TIME_WIDTH-1:0]          sample_time;
        logic                           record_end;
    } sample_t;

    typedef struct packed
    {
        logic [TIME_WIDTH-1:0]          point_time;
        logic signed [POINT_WIDTH-1:0]  point_value;
        logic                           is_maximum;
        logic                           last_of_pair;
    } point_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_max_decimator.sv =====
// Top level of the min/max peak-detect decimator.
// A closing sample's points pass through the pair register, then the output register;
//   the second point of the pair follows the first.
// Throughput: 1 sample per cycle while in_ready is high; a window close needs the pair register,
//   which drains one point at a time through the single gain multiplier as out_ready allows.
// Reset (rst_n low, asynchronous): window empty, no points pending, length 4, gain 256.
`default_nettype none

module min_max_decimator
    import mmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sample_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output point_t                    out_data,
    input  wire logic                 cfg_we,
    input  wire cfg_index_t           cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data
);

    logic [LEN_WIDTH-1:0]           window_length_reg;
    logic [GAIN_WIDTH-1:0]          gain_reg;

    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic signed [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic [TIME_WIDTH-1:0]          min_time_reg, min_time_next;
    logic [TIME_WIDTH-1:0]          max_time_reg, max_time_next;

    logic                           pair_valid_reg, pair_valid_next;
    logic                           ptr_reg, ptr_next;
    logic                           min_first_reg;
    logic signed [SAMPLE_WIDTH-1:0] pair_min_reg, pair_max_reg;
    logic [TIME_WIDTH-1:0]          pair_min_time_reg, pair_max_time_reg;

    logic                           out_valid_reg, out_valid_next;
    point_t                         out_data_reg;

    logic [LEN_WIDTH-1:0]           len_eff;
    logic [LEN_WIDTH-1:0]           count_inc;
    logic                           closes;
    logic                           accept;
    logic                           load_out;
    logic                           pair_done;
    logic                           pair_free;
    logic                           sel_max;
    logic signed [SAMPLE_WIDTH-1:0] sel_value;
    logic signed [PROD_WIDTH-1:0]   product;
    logic signed [SHIFT_WIDTH-1:0]  shifted;
    point_t                         point_next;

    always_comb
    begin
        if (window_length_reg == '0)
            len_eff = LEN_WIDTH'(1);
        else if (window_length_reg > MaxWindow)
            len_eff = MaxWindow;
        else
            len_eff = window_length_reg;
        count_inc = {1'b0, count_reg} + LEN_WIDTH'(1);
        closes    = in_data.record_end || (count_inc >= len_eff);
    end

    assign load_out  = pair_valid_reg && (!out_valid_reg || out_ready);
    assign pair_done = load_out && ptr_reg;
    assign pair_free = !pair_valid_reg || pair_done;
    assign in_ready  = pair_free || !closes;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        min_next      = min_reg;
        max_next      = max_reg;
        min_time_next = min_time_reg;
        max_time_next = max_time_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (count_reg == '0)
            begin
                min_next      = in_data.sample_value;
                max_next      = in_data.sample_value;
                min_time_next = in_data.sample_time;
                max_time_next = in_data.sample_time;
            end
            else
            begin
                if (in_data.sample_value < min_reg)
                begin
                    min_next      = in_data.sample_value;
                    min_time_next = in_data.sample_time;
                end
                if (in_data.sample_value > max_reg)
                begin
                    max_next      = in_data.sample_value;
                    max_time_next = in_data.sample_time;
                end
            end
            count_next = closes ? '0 : count_inc[COUNT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        pair_valid_next = pair_valid_reg;
        ptr_next        = ptr_reg;
        if (accept && closes)
        begin
            pair_valid_next = 1'b1;
            ptr_next        = 1'b0;
        end
        else if (pair_done)
        begin
            pair_valid_next = 1'b0;
            ptr_next        = 1'b0;
        end
        else if (load_out)
        begin
            ptr_next = 1'b1;
        end
    end

    // scale the selected extreme: floor(value * gain / 256), saturated
    always_comb
    begin
        sel_max   = ptr_reg ? min_first_reg : !min_first_reg;
        sel_value = sel_max ? pair_max_reg : pair_min_reg;
        product   = PROD_WIDTH'(sel_value) * $signed({1'b0, gain_reg});
        shifted   = product[PROD_WIDTH-1:8];
        point_next.point_time   = sel_max ? pair_max_time_reg : pair_min_time_reg;
        point_next.is_maximum   = sel_max;
        point_next.last_of_pair = ptr_reg;
        if (shifted > SHIFT_WIDTH'(8388607))
            point_next.point_value = POINT_WIDTH'(8388607);
        else if (shifted < -SHIFT_WIDTH'(8388608))
            point_next.point_value = POINT_WIDTH'(-8388608);
        else
            point_next.point_value = shifted[POINT_WIDTH-1:0];
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= ResetWindow;
            gain_reg          <= ResetGain;
            count_reg         <= '0;
            min_reg           <= '0;
            max_reg           <= '0;
            min_time_reg      <= '0;
            max_time_reg      <= '0;
            pair_valid_reg    <= 1'b0;
            ptr_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data[LEN_WIDTH-1:0];
                    REG_GAIN:          gain_reg          <= cfg_data[GAIN_WIDTH-1:0];
                    default:           gain_reg          <= gain_reg;
                endcase
            end
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            min_time_reg   <= min_time_next;
            max_time_reg   <= max_time_next;
            pair_valid_reg <= pair_valid_next;
            ptr_reg        <= ptr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && closes)
        begin
            pair_min_reg      <= min_next;
            pair_max_reg      <= max_next;
            pair_min_time_reg <= min_time_next;
            pair_max_time_reg <= max_time_next;
            min_first_reg     <= min_time_next < max_time_next;
        end
        if (load_out)
            out_data_reg <= point_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mmd_checker.sv =====
// Port-level checker for the min/max decimator and its bind.
`default_nettype none

module mmd_checker
    import mmd_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire point_t  out_data
);

    logic out_first;

    assign out_first = out_valid && out_ready && !out_data.last_of_pair;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result request changed while stalled");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_first |=> out_valid && out_data.last_of_pair)
        else $error("second point of a pair did not follow");

    a_pair_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_first |=> out_data.is_maximum != $past(out_data.is_maximum))
        else $error("pair does not hold one minimum and one maximum");

    a_min_first_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_first && !out_data.is_maximum
            |=> out_data.point_time > $past(out_data.point_time))
        else $error("minimum sent first without an earlier timestamp");

    a_max_first_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_first && out_data.is_maximum
            |=> !(out_data.point_time < $past(out_data.point_time)))
        else $error("maximum sent first although the minimum is earlier");

endmodule

bind min_max_decimator mmd_checker u_mmd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for min_max_decimator: queued sample driver, point monitor, watchdog.

module tb_top;
    import mmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RECEIVER_HOLD  = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    sample_t    in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    point_t     out_data;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    sample_t pending_samples[$];
    point_t  expected_points[$];

    logic [LEN_WIDTH-1:0]  model_len = ResetWindow;
    logic [GAIN_WIDTH-1:0] model_gain = ResetGain;
    logic signed [SAMPLE_WIDTH-1:0] win_min = '0;
    logic signed [SAMPLE_WIDTH-1:0] win_max = '0;
    logic [TIME_WIDTH-1:0] win_min_time = '0;
    logic [TIME_WIDTH-1:0] win_max_time = '0;
    int win_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    logic [TIME_WIDTH-1:0] next_time = '0;

    logic [CFG_WIDTH-1:0] phase_len [12] = '{16'd2, 16'd1, 16'd5, 16'hE000, 16'd3, 16'd12,
                                             16'd4, 16'hFFFF, 16'd6, 16'd2, 16'd9, 16'd4096};
    logic [CFG_WIDTH-1:0] phase_gain [12] = '{16'd256, 16'd65535, 16'd0, 16'd384, 16'd12345,
                                              16'd1, 16'd256, 16'd65535, 16'd40000, 16'd128,
                                              16'd32768, 16'd300};

    min_max_decimator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic point_t make_point(logic [TIME_WIDTH-1:0] t,
                                          logic signed [SAMPLE_WIDTH-1:0] v,
                                          logic is_max, logic second);
        point_t p;
        logic signed [PROD_WIDTH-1:0] a;
        logic signed [PROD_WIDTH-1:0] b;
        logic signed [PROD_WIDTH-1:0] q;
        a = v;
        b = {1'b0, model_gain};
        q = (a * b) >>> 8;
        if (q > 33'sd8388607)
            q = 33'sd8388607;
        else if (q < -33'sd8388608)
            q = -33'sd8388608;
        p.point_time   = t;
        p.point_value  = q[POINT_WIDTH-1:0];
        p.is_maximum   = is_max;
        p.last_of_pair = second;
        return p;
    endfunction

    function automatic void fold_sample(sample_t s);
        int span;
        logic signed [SAMPLE_WIDTH-1:0] v;
        v = s.sample_value;
        if (model_len == 0)
            span = 1;
        else if (model_len > MaxWindow)
            span = int'(MaxWindow);
        else
            span = int'(model_len);
        if (win_count == 0)
        begin
            win_min = v;
            win_max = v;
            win_min_time = s.sample_time;
            win_max_time = s.sample_time;
        end
        else
        begin
            if (v < win_min)
            begin
                win_min = v;
                win_min_time = s.sample_time;
            end
            if (v > win_max)
            begin
                win_max = v;
                win_max_time = s.sample_time;
            end
        end
        if (s.record_end || win_count + 1 >= span)
        begin
            win_count = 0;
            if (win_min_time < win_max_time)
            begin
                expected_points.push_back(make_point(win_min_time, win_min, 1'b0, 1'b0));
                expected_points.push_back(make_point(win_max_time, win_max, 1'b1, 1'b1));
            end
            else
            begin
                expected_points.push_back(make_point(win_max_time, win_max, 1'b1, 1'b0));
                expected_points.push_back(make_point(win_min_time, win_min, 1'b0, 1'b1));
            end
        end
        else
            win_count++;
    endfunction

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                fold_sample(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Point monitor
    always @(posedge clk)
    begin
        point_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point: time %h value %0d max %b last %b",
                           out_data.point_time, out_data.point_value,
                           out_data.is_maximum, out_data.last_of_pair);
                    mismatches++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_data.point_time !== want.point_time)
                    begin
                        $error("point_time: expected %h, got %h",
                               want.point_time, out_data.point_time);
                        mismatches++;
                    end
                    if (out_data.point_value !== want.point_value)
                    begin
                        $error("point_value: expected %0d, got %0d",
                               want.point_value, out_data.point_value);
                        mismatches++;
                    end
                    if (out_data.is_maximum !== want.is_maximum)
                    begin
                        $error("is_maximum: expected %b, got %b",
                               want.is_maximum, out_data.is_maximum);
                        mismatches++;
                    end
                    if (out_data.last_of_pair !== want.last_of_pair)
                    begin
                        $error("last_of_pair: expected %b, got %b",
                               want.last_of_pair, out_data.last_of_pair);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_asked != holds_served)
            begin
                holds_served++;
                hold_left = RECEIVER_HOLD;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
                stall_cycles++;
            else
                stall_cycles = 0;
        end
        $display("min_max_decimator verification failed");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_LENGTH)
            model_len = value[LEN_WIDTH-1:0];
        else
            model_gain = value[GAIN_WIDTH-1:0];
    endtask

    task automatic push_sample(logic signed [SAMPLE_WIDTH-1:0] v, logic [TIME_WIDTH-1:0] t,
                               logic last);
        sample_t s;
        s.sample_value = v;
        s.sample_time  = t;
        s.record_end   = last;
        pending_samples.push_back(s);
    endtask

    task automatic queue_random(int count, int end_pct);
        int vmode;
        int tmode;
        logic signed [SAMPLE_WIDTH-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            vmode = $urandom_range(7);
            tmode = $urandom_range(9);
            if (vmode < 4)
                v = SAMPLE_WIDTH'($urandom);
            else if (vmode == 4)
                v = 16'sh7FFF;
            else if (vmode == 5)
                v = 16'sh8000;
            else
                v = SAMPLE_WIDTH'(int'($urandom_range(4)) - 2);
            if (tmode == 0)
                next_time = TIME_WIDTH'({$urandom, $urandom});
            else if (tmode == 2)
                next_time = next_time - TIME_WIDTH'($urandom_range(1, 40));
            else if (tmode != 1)
                next_time = next_time + TIME_WIDTH'($urandom_range(1, 50));
            push_sample(v, next_time, $urandom_range(99) < end_pct);
        end
    endtask

    // Hold new requests until the block has drained and gone quiet
    task automatic settle();
        while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 7;
        recv_idle_pct = 49;

        push_sample(32767, 100, 1'b0);
        push_sample(-32768, 101, 1'b0);
        push_sample(0, 102, 1'b0);
        push_sample(5, 103, 1'b0);
        push_sample(10, 200, 1'b0);
        push_sample(10, 201, 1'b0);
        push_sample(3, 202, 1'b0);
        push_sample(3, 203, 1'b0);
        push_sample(-5, 300, 1'b0);
        push_sample(7, 301, 1'b0);
        push_sample(7, 302, 1'b0);
        push_sample(-5, 303, 1'b0);
        push_sample(100, 48'hFFFF_FFFF_FFFF, 1'b0);
        push_sample(-100, 48'h0, 1'b1);
        push_sample(-1, 48'h8000_0000_0000, 1'b1);
        push_sample(50, 600, 1'b0);
        push_sample(-50, 600, 1'b1);
        settle();

        write_reg(REG_WINDOW_LENGTH, 16'h0000);
        @(negedge clk);
        push_sample(1234, 700, 1'b0);
        push_sample(-1234, 701, 1'b0);
        settle();

        write_reg(REG_WINDOW_LENGTH, 16'd8);
        @(negedge clk);
        push_sample(9, 800, 1'b0);
        push_sample(-9, 801, 1'b0);
        push_sample(4, 802, 1'b0);
        push_sample(20, 803, 1'b0);
        push_sample(-20, 804, 1'b0);
        settle();

        // Shrink the open window and change gain before it closes
        write_reg(REG_WINDOW_LENGTH, 16'd3);
        write_reg(REG_GAIN, 16'd512);
        @(negedge clk);
        push_sample(0, 805, 1'b0);
        settle();

        next_time = 48'd1000;
        for (int p = 0; p < 12; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 7;
            end
            if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_WINDOW_LENGTH, phase_len[p]);
            write_reg(REG_GAIN, phase_gain[p]);
            @(negedge clk);
            if (p == 9)
                holds_asked++;
            queue_random(93, 10);
            settle();
        end

        // Open a window at the largest length, then close it with a record tail
        write_reg(REG_WINDOW_LENGTH, 16'h1FFF);
        write_reg(REG_GAIN, 16'd256);
        @(negedge clk);
        queue_random(4, 0);
        push_sample(-7, next_time + 1, 1'b1);
        settle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("min_max_decimator verification clean");
        else
            $display("min_max_decimator verification failed");
        $finish;
    end

endmodule
